### design/fsmc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsmc_pkg
// Shared types, opcodes and constants of the four-stack machine core.
// ----------------------------------------------------------------------------
package fsmc_pkg;

  localparam int STACK_DEPTH_DEF = 256;
  localparam int DATA_WORDS_DEF  = 256;
  localparam int HOLD_WORDS_DEF  = 256;
  localparam int PROG_WORDS      = 16777216;
  localparam int ROM_WORDS       = 256;
  localparam int DIV_STEPS       = 32;

  localparam logic [31:0] NAN_WORD    = 32'h8000_0000;
  localparam logic [31:0] WORD_TOP    = 32'h7fff_ffff;
  localparam logic [31:0] WORD_BOTTOM = 32'h8000_0001;
  localparam logic [31:0] SHIFT_MAX   = 32'h0000_001f;

  localparam logic [1:0] RUN_RUNNING = 2'd0;
  localparam logic [1:0] RUN_HALTED  = 2'd1;
  localparam logic [1:0] RUN_FAILED  = 2'd2;
  localparam logic [1:0] RUN_TRAPPED = 2'd3;

  typedef enum logic [5:0] {
    OP_NOOP, OP_CALL, OP_RET, OP_RPT, OP_CPUSH, OP_CPOP, OP_CPEEK, OP_CDROP,
    OP_TPUSH, OP_TPOP, OP_TPEEK, OP_TPOKE, OP_TDROP, OP_LIT, OP_DROP, OP_SWAP,
    OP_OVER, OP_ROT, OP_DUP, OP_GET, OP_PUT, OP_GETI, OP_PUTI, OP_ROM,
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_INC, OP_DEC, OP_OR,
    OP_AND, OP_XOR, OP_FLIP, OP_NEG, OP_SHL, OP_SHR, OP_HOLD, OP_GIVE,
    OP_IN, OP_OUT, OP_JUMP, OP_JNAN, OP_JNNZ, OP_JNNP, OP_JNNE, OP_JNNG,
    OP_JNNL, OP_HALT, OP_FAIL, OP_SAFE, OP_DSA, OP_DSE, OP_TSA, OP_TSE,
    OP_CSA, OP_CSE, OP_RSA, OP_RSE, OP_PMI, OP_DMW, OP_RMW, OP_HW
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_RD0, ST_RD1, ST_RD2, ST_DIV,
    ST_WR0, ST_WR1, ST_WR2, ST_TOP, ST_FIN
  } ctrl_state_t;

  typedef struct packed {
    logic [5:0]  action;
    logic [30:0] literal;
    logic [7:0]  in_byte;
    logic [23:0] return_addr;
  } item_t;

  typedef struct packed {
    logic [1:0]         run_status;
    logic               branch_taken;
    logic [23:0]        jump_target;
    logic               out_valid;
    logic [7:0]         out_byte;
    logic signed [31:0] top_value;
    logic [7:0]         data_depth;
  } result_t;

  typedef struct packed {
    logic clear;
    logic latch;
    logic rd0;
    logic rd1;
    logic rd2;
    logic div_start;
    logic wr0;
    logic wr1;
    logic wr2;
    logic top;
    logic fin;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic div_need;
    logic div_idle;
  } dp_status_t;

endpackage
`default_nettype wire

### design/fsmc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsmc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module fsmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### design/fsmc_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsmc_divider
// Restoring divider on magnitudes, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fsmc_divider (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             idle,
  output logic [31:0]      quotient,
  output logic [31:0]      remainder
);
  import fsmc_pkg::*;

  localparam int CW = $clog2(DIV_STEPS + 1);

  logic [CW-1:0] cnt;
  logic [31:0]   dvs;
  logic [32:0]   rem_sh;
  logic [32:0]   rem_sub;

  assign rem_sh  = {remainder, quotient[31]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign idle    = (cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CW'(DIV_STEPS);
    end else if (!idle) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (!idle) begin
      if (!rem_sub[32]) begin
        remainder <= rem_sub[31:0];
        quotient  <= {quotient[30:0], 1'b1};
      end else begin
        remainder <= rem_sh[31:0];
        quotient  <= {quotient[30:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

### design/fsmc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsmc_ctrl
// Sequencer: clearing pass, operand reads, divide wait, write slots, result.
// ----------------------------------------------------------------------------
module fsmc_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire fsmc_pkg::dp_status_t   status,
  output logic                        busy,
  output fsmc_pkg::ctrl_cmd_t         cmd
);
  import fsmc_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (status.clear_done) state_next = ST_IDLE;
      ST_IDLE:  if (start) state_next = ST_RD0;
      ST_RD0:   state_next = ST_RD1;
      ST_RD1:   state_next = ST_RD2;
      ST_RD2:   state_next = status.div_need ? ST_DIV : ST_WR0;
      ST_DIV:   if (status.div_idle) state_next = ST_WR0;
      ST_WR0:   state_next = ST_WR1;
      ST_WR1:   state_next = ST_WR2;
      ST_WR2:   state_next = ST_TOP;
      ST_TOP:   state_next = ST_FIN;
      ST_FIN:   state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      ST_CLEAR: cmd.clear = 1'b1;
      ST_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      ST_RD0: cmd.rd0 = 1'b1;
      ST_RD1: cmd.rd1 = 1'b1;
      ST_RD2: begin
        cmd.rd2       = 1'b1;
        cmd.div_start = status.div_need;
      end
      ST_DIV: ;
      ST_WR0: cmd.wr0 = 1'b1;
      ST_WR1: cmd.wr1 = 1'b1;
      ST_WR2: cmd.wr2 = 1'b1;
      ST_TOP: cmd.top = 1'b1;
      ST_FIN: cmd.fin = 1'b1;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### design/fsmc_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsmc_datapath
// Stack and memory RAMs, pointers, operand registers and instruction decode.
// ----------------------------------------------------------------------------
module fsmc_datapath #(
  parameter int STACK_DEPTH = fsmc_pkg::STACK_DEPTH_DEF,
  parameter int DATA_WORDS  = fsmc_pkg::DATA_WORDS_DEF,
  parameter int HOLD_WORDS  = fsmc_pkg::HOLD_WORDS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire fsmc_pkg::ctrl_cmd_t  cmd,
  input  wire fsmc_pkg::item_t      item,
  output fsmc_pkg::dp_status_t      status,
  output logic                      done,
  output fsmc_pkg::result_t         result
);
  import fsmc_pkg::*;

  localparam int PW   = $clog2(STACK_DEPTH);
  localparam int DAW  = $clog2(DATA_WORDS);
  localparam int HAW  = $clog2(HOLD_WORDS);
  localparam int MAXW = (DATA_WORDS > HOLD_WORDS) ? DATA_WORDS : HOLD_WORDS;
  localparam int CW   = $clog2(MAXW);
  localparam logic [PW-1:0] FULL = PW'(STACK_DEPTH - 1);

  item_t         item_q;
  op_t           op;
  logic [PW-1:0] d, tp, cp, rp;
  logic [1:0]    st;
  logic [31:0]   t1, n2, n3, t_top, c_top, m1, m2, h1;
  logic [23:0]   r_top;
  logic signed [63:0] prod;
  logic [CW-1:0] clr_cnt;

  logic [PW-1:0] d_new, t_new, c_new, r_new;
  logic [2:0]    dwen;
  logic [PW-1:0] dwa [3];
  logic [31:0]   dwd [3];
  logic          twen, cwen, rwen, dmwen, hmwen;
  logic [PW-1:0] twa, cwa;
  logic [31:0]   twd, cwd, dmwd, hmwd;
  logic [DAW-1:0] dmwa;
  logic [HAW-1:0] hmwa;
  logic [1:0]    st_new;
  logic          br, ov, fault, do_push;
  logic [23:0]   tgt;
  logic [7:0]    ob;
  logic [31:0]   pushv, binres, cdec;
  logic [1:0]    npop;

  logic        nan_in, bad_shift;
  logic [32:0] sum33, diff33;
  logic [31:0] div_q, div_r, qs, rs_val;
  logic        div_idle;

  logic          ds_we, dm_we, hm_we;
  logic [PW-1:0] ds_waddr, ds_raddr;
  logic [31:0]   ds_wdata, ds_rdata, ts_rdata, cs_rdata, dm_wdata, dm_rdata;
  logic [31:0]   hm_wdata, hm_rdata;
  logic [23:0]   rs_rdata;
  logic [DAW-1:0] dm_waddr, dm_raddr;
  logic [HAW-1:0] hm_waddr;

  assign op = op_t'(item_q.action);

  // operand capture
  always_ff @(posedge clk) begin
    if (cmd.latch) item_q <= item;
    if (cmd.rd1) begin
      n2    <= ds_rdata;
      t_top <= ts_rdata;
      c_top <= cs_rdata;
      r_top <= rs_rdata;
      m1    <= dm_rdata;
      h1    <= hm_rdata;
    end
    if (cmd.rd2) begin
      n3 <= ds_rdata;
      m2 <= dm_rdata;
    end
    prod <= $signed(n2) * $signed(t1);
    if (cmd.fin) t1 <= (d != '0) ? ds_rdata : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d       <= '0;
      tp      <= '0;
      cp      <= '0;
      rp      <= '0;
      st      <= RUN_RUNNING;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      done <= cmd.fin;
      if (cmd.clear) clr_cnt <= clr_cnt + 1'b1;
      if (cmd.top) begin
        d  <= d_new;
        tp <= t_new;
        cp <= c_new;
        rp <= r_new;
        st <= st_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.top) begin
      result.run_status   <= st_new;
      result.branch_taken <= br;
      result.jump_target  <= tgt;
      result.out_valid    <= ov;
      result.out_byte     <= ob;
      result.data_depth   <= 8'(d_new);
    end
    if (cmd.fin) result.top_value <= (d != '0) ? ds_rdata : '0;
  end

  // arithmetic
  assign nan_in    = (t1 == NAN_WORD) || (n2 == NAN_WORD);
  assign bad_shift = t1 > SHIFT_MAX;
  assign sum33     = {n2[31], n2} + {t1[31], t1};
  assign diff33    = {n2[31], n2} - {t1[31], t1};
  assign qs        = (n2[31] ^ t1[31]) ? (~div_q + 1'b1) : div_q;
  assign rs_val    = n2[31] ? (~div_r + 1'b1) : div_r;
  assign cdec      = c_top - 1'b1;

  always_comb begin
    binres = NAN_WORD;
    if (!nan_in) begin
      case (op)
        OP_ADD: if (sum33[32] == sum33[31] && sum33[31:0] != NAN_WORD) binres = sum33[31:0];
        OP_SUB: if (diff33[32] == diff33[31] && diff33[31:0] != NAN_WORD)
          binres = diff33[31:0];
        OP_MUL: if ((&prod[63:31] || ~|prod[63:31]) && prod[31:0] != NAN_WORD)
          binres = prod[31:0];
        OP_DIV: if (t1 != '0) binres = qs;
        OP_MOD: if (t1 != '0) binres = rs_val;
        OP_OR:  binres = n2 | t1;
        OP_AND: binres = n2 & t1;
        OP_XOR: binres = n2 ^ t1;
        OP_SHL: if (!bad_shift) binres = n2 << t1[4:0];
        OP_SHR: if (!bad_shift) binres = $unsigned($signed(n2) >>> t1[4:0]);
        default: binres = NAN_WORD;
      endcase
    end
  end

  assign status.div_need = (st == RUN_RUNNING) && (op == OP_DIV || op == OP_MOD)
                           && (d >= PW'(2)) && !nan_in && (t1 != '0);
  assign status.div_idle = div_idle;
  assign status.clear_done = (clr_cnt == CW'(MAXW - 1));

  fsmc_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (n2[31] ? (~n2 + 1'b1) : n2),
    .divisor   (t1[31] ? (~t1 + 1'b1) : t1),
    .idle      (div_idle),
    .quotient  (div_q),
    .remainder (div_r)
  );

  // instruction decode
  always_comb begin
    d_new = d; t_new = tp; c_new = cp; r_new = rp;
    dwen = '0;
    for (int k = 0; k < 3; k++) begin
      dwa[k] = '0;
      dwd[k] = '0;
    end
    twen = 1'b0; twa = '0; twd = '0;
    cwen = 1'b0; cwa = '0; cwd = '0;
    rwen = 1'b0;
    dmwen = 1'b0; dmwa = '0; dmwd = '0;
    hmwen = 1'b0; hmwa = '0; hmwd = '0;
    st_new = st; br = 1'b0; tgt = '0; ov = 1'b0; ob = '0;
    fault = 1'b0; do_push = 1'b0; pushv = '0; npop = 2'd0;

    if (st == RUN_RUNNING) begin
      unique case (op)
        OP_CPUSH, OP_TPUSH, OP_DROP, OP_GET, OP_GETI, OP_ROM, OP_INC, OP_DEC,
        OP_FLIP, OP_NEG, OP_GIVE, OP_OUT, OP_JNNE, OP_JNNG, OP_JNNL: npop = 2'd1;
        OP_TPOKE, OP_PUT, OP_PUTI, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD,
        OP_OR, OP_AND, OP_XOR, OP_SHL, OP_SHR, OP_HOLD: npop = 2'd2;
        default: npop = 2'd0;
      endcase

      if (d < PW'(npop)) begin
        fault = 1'b1;
        d_new = '0;
      end else begin
        d_new = d - PW'(npop);
      end

      if (!fault) begin
        unique case (op)
          OP_NOOP: ;
          OP_CALL: begin
            if (rp == FULL) fault = 1'b1;
            else begin
              rwen = 1'b1; r_new = rp + 1'b1; br = 1'b1;
            end
          end
          OP_RET: begin
            if (rp == '0) fault = 1'b1;
            else begin
              r_new = rp - 1'b1; tgt = r_top; br = 1'b1;
            end
          end
          OP_RPT: begin
            if (cp == '0) fault = 1'b1;
            else if (c_top != '0 && c_top != NAN_WORD) begin
              cwen = 1'b1; cwa = cp - 1'b1; cwd = cdec;
              br = !cdec[31] && (cdec != '0);
            end
          end
          OP_CPUSH: begin
            if (cp == FULL) fault = 1'b1;
            else begin
              cwen = 1'b1; cwa = cp; cwd = t1; c_new = cp + 1'b1;
            end
          end
          OP_CPOP: begin
            if (cp == '0) fault = 1'b1;
            else begin
              c_new = cp - 1'b1; do_push = 1'b1; pushv = c_top;
            end
          end
          OP_CPEEK: begin
            if (cp == '0) fault = 1'b1;
            else begin
              do_push = 1'b1; pushv = c_top;
            end
          end
          OP_CDROP: begin
            if (cp == '0) fault = 1'b1;
            else c_new = cp - 1'b1;
          end
          OP_TPUSH: begin
            if (tp == FULL) fault = 1'b1;
            else begin
              twen = 1'b1; twa = tp; twd = t1; t_new = tp + 1'b1;
            end
          end
          OP_TPOP: begin
            if (tp == '0) fault = 1'b1;
            else begin
              t_new = tp - 1'b1; do_push = 1'b1; pushv = t_top;
            end
          end
          OP_TPEEK: begin
            if (tp == '0) fault = 1'b1;
            else begin
              do_push = 1'b1; pushv = t_top;
            end
          end
          OP_TPOKE: begin
            if (t1[31] || t1 == '0 || t1 > 32'(tp)) fault = 1'b1;
            else begin
              twen = 1'b1; twa = tp - t1[PW-1:0]; twd = n2;
            end
          end
          OP_TDROP: begin
            if (tp == '0) fault = 1'b1;
            else t_new = tp - 1'b1;
          end
          OP_LIT: begin
            do_push = 1'b1; pushv = {1'b0, item_q.literal};
          end
          OP_DROP: ;
          OP_SWAP: begin
            if (d < PW'(2)) fault = 1'b1;
            else begin
              dwen = 3'b011;
              dwa[0] = d - 1'b1; dwd[0] = n2;
              dwa[1] = d - PW'(2); dwd[1] = t1;
            end
          end
          OP_OVER: begin
            if (d < PW'(2)) fault = 1'b1;
            else begin
              do_push = 1'b1; pushv = n2;
            end
          end
          OP_ROT: begin
            if (d < PW'(3)) fault = 1'b1;
            else begin
              dwen = 3'b111;
              dwa[0] = d - PW'(2); dwd[0] = t1;
              dwa[1] = d - PW'(3); dwd[1] = n2;
              dwa[2] = d - 1'b1;   dwd[2] = n3;
            end
          end
          OP_DUP: begin
            if (d == '0) fault = 1'b1;
            else begin
              do_push = 1'b1; pushv = t1;
            end
          end
          OP_GET: begin
            if (t1 >= 32'(DATA_WORDS)) fault = 1'b1;
            else begin
              do_push = 1'b1; pushv = m1;
            end
          end
          OP_PUT: begin
            if (t1 >= 32'(DATA_WORDS)) fault = 1'b1;
            else begin
              dmwen = 1'b1; dmwa = t1[DAW-1:0]; dmwd = n2;
            end
          end
          OP_GETI: begin
            if (t1 >= 32'(DATA_WORDS) || m1 >= 32'(DATA_WORDS)) fault = 1'b1;
            else begin
              do_push = 1'b1; pushv = m2;
            end
          end
          OP_PUTI: begin
            if (t1 >= 32'(DATA_WORDS) || m1 >= 32'(DATA_WORDS)) fault = 1'b1;
            else begin
              dmwen = 1'b1; dmwa = m1[DAW-1:0]; dmwd = n2;
            end
          end
          OP_ROM: begin
            if (t1 >= 32'(ROM_WORDS)) fault = 1'b1;
            else begin
              do_push = 1'b1; pushv = '0;
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_OR, OP_AND, OP_XOR,
          OP_SHL, OP_SHR: begin
            do_push = 1'b1; pushv = binres;
          end
          OP_INC: begin
            do_push = 1'b1;
            pushv = (t1 == NAN_WORD || t1 == WORD_TOP) ? NAN_WORD : t1 + 1'b1;
          end
          OP_DEC: begin
            do_push = 1'b1;
            pushv = (t1 == NAN_WORD || t1 == WORD_BOTTOM) ? NAN_WORD : t1 - 1'b1;
          end
          OP_FLIP: begin
            do_push = 1'b1;
            pushv = (t1 == NAN_WORD) ? NAN_WORD : t1 ^ NAN_WORD;
          end
          OP_NEG: begin
            do_push = 1'b1;
            pushv = (t1 == NAN_WORD) ? NAN_WORD : ~t1 + 1'b1;
          end
          OP_HOLD: begin
            if (t1 >= 32'(HOLD_WORDS)) fault = 1'b1;
            else begin
              hmwen = 1'b1; hmwa = t1[HAW-1:0]; hmwd = n2;
            end
          end
          OP_GIVE: begin
            if (t1 >= 32'(HOLD_WORDS)) fault = 1'b1;
            else begin
              do_push = 1'b1; pushv = h1;
            end
          end
          OP_IN: begin
            do_push = 1'b1; pushv = {24'd0, item_q.in_byte};
          end
          OP_OUT: begin
            ov = 1'b1; ob = t1[7:0];
          end
          OP_JUMP: br = 1'b1;
          OP_JNAN: begin
            if (d == '0) fault = 1'b1;
            else br = (t1 == NAN_WORD);
          end
          OP_JNNZ: begin
            if (d == '0) fault = 1'b1;
            else br = (t1 == '0);
          end
          OP_JNNP: begin
            if (d == '0) fault = 1'b1;
            else br = !t1[31] && (t1 != '0);
          end
          OP_JNNE, OP_JNNG, OP_JNNL: begin
            if (d < PW'(2)) fault = 1'b1;
            else if (!nan_in) begin
              if (op == OP_JNNE) br = (n2 == t1);
              else if (op == OP_JNNG) br = ($signed(n2) > $signed(t1));
              else br = ($signed(n2) < $signed(t1));
            end
          end
          OP_HALT: st_new = RUN_HALTED;
          OP_FAIL: st_new = RUN_FAILED;
          OP_SAFE: br = (d < PW'(2));
          OP_DSA: begin do_push = 1'b1; pushv = 32'(d); end
          OP_DSE: begin do_push = 1'b1; pushv = 32'(STACK_DEPTH - 1) - 32'(d); end
          OP_TSA: begin do_push = 1'b1; pushv = 32'(tp); end
          OP_TSE: begin do_push = 1'b1; pushv = 32'(STACK_DEPTH - 1) - 32'(tp); end
          OP_CSA: begin do_push = 1'b1; pushv = 32'(cp); end
          OP_CSE: begin do_push = 1'b1; pushv = 32'(STACK_DEPTH - 1) - 32'(cp); end
          OP_RSA: begin do_push = 1'b1; pushv = 32'(rp); end
          OP_RSE: begin do_push = 1'b1; pushv = 32'(STACK_DEPTH - 1) - 32'(rp); end
          OP_PMI: begin do_push = 1'b1; pushv = 32'(PROG_WORDS); end
          OP_DMW: begin do_push = 1'b1; pushv = 32'(DATA_WORDS); end
          OP_RMW: begin do_push = 1'b1; pushv = 32'(ROM_WORDS); end
          OP_HW:  begin do_push = 1'b1; pushv = 32'(HOLD_WORDS); end
          default: ;
        endcase
      end

      if (do_push && !fault) begin
        if (d_new == FULL) fault = 1'b1;
        else begin
          dwen[0] = 1'b1; dwa[0] = d_new; dwd[0] = pushv;
          d_new = d_new + 1'b1;
        end
      end

      if (fault) begin
        st_new = RUN_TRAPPED;
        br = 1'b0; tgt = '0; ov = 1'b0; ob = '0;
      end
    end
  end

  // ram port muxing
  always_comb begin
    ds_we = 1'b0; ds_waddr = dwa[0]; ds_wdata = dwd[0];
    if (cmd.wr0) begin
      ds_we = dwen[0];
    end else if (cmd.wr1) begin
      ds_we = dwen[1]; ds_waddr = dwa[1]; ds_wdata = dwd[1];
    end else if (cmd.wr2) begin
      ds_we = dwen[2]; ds_waddr = dwa[2]; ds_wdata = dwd[2];
    end
    if (cmd.rd0) ds_raddr = d - PW'(2);
    else if (cmd.rd1) ds_raddr = d - PW'(3);
    else ds_raddr = d_new - 1'b1;

    dm_raddr = cmd.rd1 ? dm_rdata[DAW-1:0] : t1[DAW-1:0];

    if (cmd.clear) begin
      dm_we = ({1'b0, clr_cnt} < (CW+1)'(DATA_WORDS));
      dm_waddr = clr_cnt[DAW-1:0]; dm_wdata = '0;
      hm_we = ({1'b0, clr_cnt} < (CW+1)'(HOLD_WORDS));
      hm_waddr = clr_cnt[HAW-1:0]; hm_wdata = '0;
    end else begin
      dm_we = cmd.wr0 && dmwen; dm_waddr = dmwa; dm_wdata = dmwd;
      hm_we = cmd.wr0 && hmwen; hm_waddr = hmwa; hm_wdata = hmwd;
    end
  end

  fsmc_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ds (
    .clk(clk), .we(ds_we), .waddr(ds_waddr), .wdata(ds_wdata),
    .raddr(ds_raddr), .rdata(ds_rdata)
  );

  fsmc_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_ts (
    .clk(clk), .we(cmd.wr0 && twen), .waddr(twa), .wdata(twd),
    .raddr(tp - 1'b1), .rdata(ts_rdata)
  );

  fsmc_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_cs (
    .clk(clk), .we(cmd.wr0 && cwen), .waddr(cwa), .wdata(cwd),
    .raddr(cp - 1'b1), .rdata(cs_rdata)
  );

  fsmc_ram #(.WIDTH(24), .DEPTH(STACK_DEPTH)) u_rs (
    .clk(clk), .we(cmd.wr0 && rwen), .waddr(rp), .wdata(item_q.return_addr),
    .raddr(rp - 1'b1), .rdata(rs_rdata)
  );

  fsmc_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dm (
    .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
    .raddr(dm_raddr), .rdata(dm_rdata)
  );

  fsmc_ram #(.WIDTH(32), .DEPTH(HOLD_WORDS)) u_hm (
    .clk(clk), .we(hm_we), .waddr(hm_waddr), .wdata(hm_wdata),
    .raddr(t1[HAW-1:0]), .rdata(hm_rdata)
  );

endmodule
`default_nettype wire

### design/four_stack_machine_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// four_stack_machine_core
// Executes one instruction per transfer on a four-stack machine with data and
// hold memories. After reset the core sweeps the data and hold memories to
// zero, one word per cycle, with busy high. An instruction then steps through
// the operand reads (RD0 to RD2), the write slots (WR0 to WR2), the top
// refresh and the result states on the stack RAMs, which have one read and
// one write port each; div and mod also wait in a divide state for the
// bit-serial divider. done is high for one cycle with the result and
// cannot be held off; busy is already low in that cycle.
// ----------------------------------------------------------------------------
module four_stack_machine_core #(
  parameter int STACK_DEPTH = fsmc_pkg::STACK_DEPTH_DEF,
  parameter int DATA_WORDS  = fsmc_pkg::DATA_WORDS_DEF,
  parameter int HOLD_WORDS  = fsmc_pkg::HOLD_WORDS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire fsmc_pkg::item_t   item,
  output logic                   done,
  output fsmc_pkg::result_t      result
);
  import fsmc_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  fsmc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .busy   (busy),
    .cmd    (cmd)
  );

  fsmc_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .DATA_WORDS  (DATA_WORDS),
    .HOLD_WORDS  (HOLD_WORDS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .item   (item),
    .status (status),
    .done   (done),
    .result (result)
  );

endmodule
`default_nettype wire

### design/fsmc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fsmc_checker
// Port-level checks of the instruction and result transfers.
// ----------------------------------------------------------------------------
module fsmc_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               done,
  input wire fsmc_pkg::result_t  result
);
  import fsmc_pkg::*;

  // an accepted transfer keeps the core busy
  assert property (@(posedge clk) disable iff (rst) start && !busy |=> busy)
    else $error("core not busy after accepting a transfer");

  // result strobe lasts exactly one cycle
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  // no result right after an accept
  assert property (@(posedge clk) disable iff (rst) start && !busy |=> !done)
    else $error("result strobe right after accept");

  // a stopped machine stays stopped
  assert property (@(posedge clk) disable iff (rst)
    done && result.run_status != RUN_RUNNING |=> result.run_status == $past(result.run_status))
    else $error("run status left a stopped state");

endmodule

bind four_stack_machine_core fsmc_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
`default_nettype wire
